@@ design/suvt_pkg.sv @@
package suvt_pkg;

  // request mode codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_ERASE  = 2'd2;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic               was_present;
    logic               inserted;
    logic               removed;
    logic               rejected_full;
    logic [KEY_W-1:0]   assigned_key;
    logic [COUNT_W-1:0] entry_count;
  } out_word_t;

  // one stored entry: serial key and value
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SEARCH   = 6'b000010,
    ST_SHIFT_UP = 6'b000100,
    ST_WRITE    = 6'b001000,
    ST_SHIFT_DN = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

endpackage

@@ design/sorted_unique_value_table_top.sv @@
// channel | direction | handshake                | word
// --------+-----------+--------------------------+----------------------------
// in      | input     | in_valid_i / in_stall_o  | suvt_pkg::in_word_t (mode, value)
// out     | output    | out_valid_o / out_stall_i| suvt_pkg::out_word_t (flags, key, count)
//
// one request at a time; one memory read and write port and one signed comparator
// a request that changes nothing only scans up to its sorted position; an insert that
// adds also shifts the entries from that position up by one; an erase that removes shifts
// the entries above it down by one; in_stall_o is high until the word enters the output register
// a stalled output word holds the sequencer in its last step, so the next request waits
// reset clears the count, the key counter and control; only entries below the count affect a result
module sorted_unique_value_table_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  suvt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output suvt_pkg::out_word_t out_word_o
);

  // address and count widths follow the capacity
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // entry memory, one read and one write port, registered read data
  suvt_pkg::entry_t mem_q [CAPACITY];
  suvt_pkg::entry_t rd_data_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  suvt_pkg::entry_t wr_data;

  // sequencer state
  suvt_pkg::state_e state_q, state_d;
  logic [CW-1:0]    idx_q, idx_d;     // scan index, then the sorted position
  logic [CW-1:0]    j_q, j_d;         // shift index
  logic [CW-1:0]    count_q, count_d;
  logic [suvt_pkg::KEY_W-1:0] key_q, key_d;
  logic [1:0]       mode_q, mode_d;
  logic signed [suvt_pkg::VALUE_W-1:0] val_q, val_d;

  // result being built, and the output register
  suvt_pkg::out_word_t res_q, res_d;
  suvt_pkg::out_word_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // scan compare and shift bookkeeping
  logic          at_end;
  logic          less;
  logic          present;
  logic [CW:0]   idx_p1;
  logic [CW:0]   j_p2;
  logic [CW:0]   count_x;
  logic [31:0]   count_ext;

  assign at_end  = (idx_q >= count_q);
  assign less    = (rd_data_q.value < val_q);
  assign present = !at_end && (rd_data_q.value == val_q);
  assign idx_p1  = {1'b0, idx_q} + 1'b1;
  assign j_p2    = {1'b0, j_q} + 2'd2;
  assign count_x = {1'b0, count_q};
  assign count_ext = 32'(count_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    j_d         = j_q;
    count_d     = count_q;
    key_d       = key_q;
    mode_d      = mode_q;
    val_d       = val_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_addr     = idx_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = j_q[AW-1:0];
    wr_data     = rd_data_q;

    // output register drains independently of the sequencer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      suvt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = in_word_i.mode;
          val_d   = in_word_i.value;
          idx_d   = '0;
          rd_addr = '0;
          res_d   = '0;
          state_d = suvt_pkg::ST_SEARCH;
        end
      end

      // walk up the sorted entries until the first one not below the value
      suvt_pkg::ST_SEARCH: begin
        if (!at_end && less) begin
          idx_d   = idx_p1[CW-1:0];
          rd_addr = idx_p1[AW-1:0];
        end else begin
          res_d.was_present = present;
          if (mode_q == suvt_pkg::MODE_INSERT && !present) begin
            if (count_q == CapCount) begin
              res_d.rejected_full = 1'b1;
              state_d = suvt_pkg::ST_DONE;
            end else if (count_q > idx_q) begin
              j_d     = count_q;
              rd_addr = AW'(count_q - 1'b1);
              state_d = suvt_pkg::ST_SHIFT_UP;
            end else begin
              state_d = suvt_pkg::ST_WRITE;
            end
          end else if (mode_q == suvt_pkg::MODE_ERASE && present) begin
            res_d.removed = 1'b1;
            if (idx_p1 < count_x) begin
              j_d     = idx_q;
              rd_addr = idx_p1[AW-1:0];
              state_d = suvt_pkg::ST_SHIFT_DN;
            end else begin
              count_d = count_q - 1'b1;
              state_d = suvt_pkg::ST_DONE;
            end
          end else begin
            state_d = suvt_pkg::ST_DONE;
          end
        end
      end

      // open a gap: entry j-1 moves to j, top down
      suvt_pkg::ST_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = j_q[AW-1:0];
        wr_data = rd_data_q;
        if ((j_q - 1'b1) > idx_q) begin
          j_d     = j_q - 1'b1;
          rd_addr = AW'(j_q - 2'd2);
        end else begin
          state_d = suvt_pkg::ST_WRITE;
        end
      end

      suvt_pkg::ST_WRITE: begin
        wr_en              = 1'b1;
        wr_addr            = idx_q[AW-1:0];
        wr_data.key        = key_q;
        wr_data.value      = val_q;
        key_d              = key_q + 1'b1;
        count_d            = count_q + 1'b1;
        res_d.inserted     = 1'b1;
        res_d.assigned_key = key_q;
        state_d            = suvt_pkg::ST_DONE;
      end

      // close the gap: entry j+1 moves to j, bottom up
      suvt_pkg::ST_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = j_q[AW-1:0];
        wr_data = rd_data_q;
        if (j_p2 < count_x) begin
          j_d     = j_q + 1'b1;
          rd_addr = j_p2[AW-1:0];
        end else begin
          count_d = count_q - 1'b1;
          state_d = suvt_pkg::ST_DONE;
        end
      end

      // wait for a free output register
      suvt_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d             = res_q;
          out_d.entry_count = count_ext[suvt_pkg::COUNT_W-1:0];
          out_valid_d       = 1'b1;
          state_d           = suvt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = suvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= suvt_pkg::ST_IDLE;
      count_q     <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    j_q    <= j_d;
    mode_q <= mode_d;
    val_q  <= val_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != suvt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  // fill level never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("entry count above capacity");

  // the key counter moves only together with a new entry
  a_key_with_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_q != $past(key_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("key counter moved without an insert");

  // an opening shift stays above the insert position
  a_shift_up_above_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == suvt_pkg::ST_SHIFT_UP) |-> (j_q > idx_q))
    else $error("shift index at or below insert position");

  // a result appears only on leaving the final step
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == suvt_pkg::ST_DONE))
    else $error("result word without finished request");
`endif

endmodule

@@ tb/sv/tb_sorted_unique_value_table_top.sv @@
module tb_sorted_unique_value_table_top;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned MAX_WAIT      = 13;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  // worst request is an insert into a nearly full table
  localparam int unsigned SETTLE_CYCLES = 2 * CAPACITY + 10;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned REPORT_MAX    = 10;

  // mode three has no name in the package; the block treats it as a look up
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int VAL_MIN = 32'sh8000_0000;
  localparam int VAL_MAX = 32'sh7fff_ffff;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  suvt_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  suvt_pkg::out_word_t out_word_o;

  // table as the block should hold it, ascending, plus the next serial key
  int                         tbl_value [CAPACITY];
  logic [suvt_pkg::KEY_W-1:0] tbl_key   [CAPACITY];
  int                         tbl_count;
  logic [suvt_pkg::KEY_W-1:0] key_next;

  suvt_pkg::out_word_t pending_replies[$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  // idling controls for sender and receiver
  bit idle_on   = 1'b0;
  bit stall_on  = 1'b0;
  int stall_left = 0;

  sorted_unique_value_table_top #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // applies one request to the table copy and returns the word it should produce
  function automatic suvt_pkg::out_word_t apply_request(suvt_pkg::in_word_t w);
    int                  v;
    int                  pos;
    bit                  hit;
    suvt_pkg::out_word_t r;
    v   = w.value;
    pos = 0;
    while (pos < tbl_count && tbl_value[pos] < v) pos++;
    hit = (pos < tbl_count) && (tbl_value[pos] == v);
    r = '0;
    r.was_present = hit;
    case (w.mode)
      suvt_pkg::MODE_INSERT: begin
        if (!hit) begin
          if (tbl_count >= CAPACITY) begin
            r.rejected_full = 1'b1;
          end else begin
            for (int i = tbl_count; i > pos; i--) begin
              tbl_value[i] = tbl_value[i-1];
              tbl_key[i]   = tbl_key[i-1];
            end
            tbl_value[pos]  = v;
            tbl_key[pos]    = key_next;
            r.inserted      = 1'b1;
            r.assigned_key  = key_next;
            key_next        = key_next + 1'b1;
            tbl_count++;
          end
        end
      end
      suvt_pkg::MODE_ERASE: begin
        if (hit) begin
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_value[i] = tbl_value[i+1];
            tbl_key[i]   = tbl_key[i+1];
          end
          tbl_count--;
          r.removed = 1'b1;
        end
      end
      default: begin
        // look up and mode three leave the table alone
      end
    endcase
    r.entry_count = suvt_pkg::COUNT_W'(tbl_count);
    return r;
  endfunction

  // present value from the table, or a fresh one: wide random, extremes, small
  function automatic int pick_value(bit from_table);
    int sel;
    sel = $urandom_range(0, 9);
    if (from_table && tbl_count > 0) return tbl_value[$urandom_range(0, tbl_count - 1)];
    if (sel < 3) return $urandom();
    if (sel < 5) begin
      case ($urandom_range(0, 6))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        3: return VAL_MAX - 1;
        4: return -1;
        5: return 1;
        default: return 0;
      endcase
    end
    return int'($urandom_range(0, 48)) - 24;
  endfunction

  task automatic drive_idle_word();
    suvt_pkg::in_word_t junk;
    junk.mode  = 2'($urandom_range(0, 3));
    junk.value = $urandom();
    in_valid_i <= 1'b0;
    in_word_i  <= junk;
  endtask

  // sends one request word, predicts its reply once accepted, then idles a while
  task automatic send_request(input logic [1:0] mode, input int value);
    suvt_pkg::in_word_t w;
    int                 gap;
    w.mode  = mode;
    w.value = value;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_replies.push_back(apply_request(w));
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      drive_idle_word();
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // sender holds off until every predicted reply has come back
  task automatic wait_for_replies();
    @(negedge clk_i);
    drive_idle_word();
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // extremes fill the table, then a duplicate and a refused insert when full
  task automatic test_fill_to_capacity();
    int fill_values[16] = '{VAL_MIN, VAL_MAX, 0, -1, 1, VAL_MIN + 1, VAL_MAX - 1,
                            32'sh5555_5555, 32'shaaaa_aaaa, -100, 100, 7, -7,
                            1000, -1000, 42};
    idle_on  = 1'b0;
    stall_on = 1'b0;
    foreach (fill_values[i]) send_request(suvt_pkg::MODE_INSERT, fill_values[i]);
    send_request(suvt_pkg::MODE_INSERT, VAL_MAX);
    send_request(suvt_pkg::MODE_INSERT, 3);
  endtask

  // look ups, mode three, erase hit and miss, then an insert fits again
  task automatic test_lookup_and_erase();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_request(suvt_pkg::MODE_LOOKUP, VAL_MIN);
    send_request(suvt_pkg::MODE_LOOKUP, 2);
    send_request(MODE_SPARE, 0);
    send_request(suvt_pkg::MODE_ERASE, VAL_MAX);
    send_request(suvt_pkg::MODE_ERASE, 2);
    send_request(suvt_pkg::MODE_INSERT, 3);
    send_request(suvt_pkg::MODE_LOOKUP, 3);
  endtask

  // phases that lean toward filling or draining, idling switched per phase
  task automatic test_random_traffic(input int n_items);
    int sent;
    int phase_len;
    int pick;
    int ins_cut;
    int era_cut;
    bit filling;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(15, 50);
      filling   = (tbl_count < CAPACITY / 2) ? ($urandom_range(0, 3) != 0)
                                             : ($urandom_range(0, 3) == 0);
      ins_cut   = filling ? 55 : 20;
      era_cut   = filling ? 70 : 75;
      idle_on   = $urandom_range(0, 3) != 0;
      stall_on  = $urandom_range(0, 3) != 0;
      for (int i = 0; i < phase_len && sent < n_items; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < ins_cut)
          send_request(suvt_pkg::MODE_INSERT, pick_value($urandom_range(0, 4) == 0));
        else if (pick < era_cut)
          send_request(suvt_pkg::MODE_ERASE, pick_value($urandom_range(0, 3) != 0));
        else if (pick < 95)
          send_request(suvt_pkg::MODE_LOOKUP, pick_value($urandom_range(0, 1)));
        else
          send_request(MODE_SPARE, pick_value($urandom_range(0, 1)));
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_for_replies();
    end
  endtask

  task automatic note_mismatch(input string what, input suvt_pkg::out_word_t want,
                               input suvt_pkg::out_word_t got);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("mismatch (%s) at %0t: expected present=%0b ins=%0b rem=%0b full=%0b",
               what, $time, want.was_present, want.inserted, want.removed,
               want.rejected_full);
      $display("  expected key=%0d cnt=%0d", want.assigned_key, want.entry_count);
      $display("  actual   present=%0b ins=%0b rem=%0b full=%0b key=%0d cnt=%0d",
               got.was_present, got.inserted, got.removed, got.rejected_full,
               got.assigned_key, got.entry_count);
    end
  endtask

  // reply checker: each accepted word against the oldest prediction
  always @(posedge clk_i) begin
    suvt_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left = stall_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (pending_replies.size() == 0) begin
        note_mismatch("no request waiting", '0, out_word_o);
      end else begin
        want = pending_replies.pop_front();
        if (out_word_o.was_present   !== want.was_present   ||
            out_word_o.inserted      !== want.inserted      ||
            out_word_o.removed       !== want.removed       ||
            out_word_o.rejected_full !== want.rejected_full ||
            out_word_o.assigned_key  !== want.assigned_key  ||
            out_word_o.entry_count   !== want.entry_count)
          note_mismatch("field", want, out_word_o);
      end
    end
  end

  // receiver holds each reply word for its drawn number of cycles
  always @(negedge clk_i) begin
    if (out_valid_o && stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (!out_valid_o && stall_on) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // key counter wrap needs 2^31 inserts and is out of reach here
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    tbl_count  = 0;
    key_next   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_to_capacity();
    test_lookup_and_erase();
    wait_for_replies();
    test_random_traffic(RANDOM_ITEMS);
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/suvt_pkg.sv
design/sorted_unique_value_table_top.sv
tb/sv/tb_sorted_unique_value_table_top.sv
